### sv/clsr_pkg.sv
// shared constants and types for the combined lcg shuffle generator
`timescale 1ns / 1ps

package clsr_pkg;

    // value and multiplier widths
    localparam int VAL_W  = 31;
    localparam int MUL_W  = 16;
    localparam int PROD_W = VAL_W + MUL_W;
    localparam int HI_W   = PROD_W - VAL_W;
    localparam int FOLD_W = 8;

    // generator constants
    localparam logic [VAL_W-1:0]  MOD_ONE      = 31'd2147483563;
    localparam logic [VAL_W-1:0]  MOD_TWO      = 31'd2147483399;
    localparam logic [MUL_W-1:0]  MUL_ONE      = 16'd40014;
    localparam logic [MUL_W-1:0]  MUL_TWO      = 16'd40692;
    // 2^31 minus each modulus, used to fold the high product bits
    localparam logic [FOLD_W-1:0] FOLD_ONE     = 8'd85;
    localparam logic [FOLD_W-1:0] FOLD_TWO     = 8'd249;
    localparam logic [VAL_W-1:0]  TOP_VALUE    = 31'd2147483562;
    localparam logic [VAL_W-1:0]  FIRST_RESET  = 31'd1;
    localparam logic [VAL_W-1:0]  SECOND_RESET = 31'd123456789;

    // default shuffle table depth
    localparam int TABLE_SIZE_DEF = 32;

    // item kinds
    localparam logic KIND_DRAW   = 1'b0;
    localparam logic KIND_RESEED = 1'b1;

    // control of the shared modular multiply unit
    typedef struct packed {
        logic mul_en;
        logic sel_two;
    } lehmer_ctl_t;

endpackage

### sv/clsr_lehmer_unit.sv
// shared modular multiply unit for both generators
`timescale 1ns / 1ps

module clsr_lehmer_unit (
    input  logic                      aclk,
    input  clsr_pkg::lehmer_ctl_t     ctl,
    input  logic [clsr_pkg::VAL_W-1:0] operand,
    output logic [clsr_pkg::VAL_W-1:0] result
);

    logic [clsr_pkg::PROD_W-1:0] prod_reg;
    logic                        sel_reg;
    logic [clsr_pkg::MUL_W-1:0]  mul_const;
    logic [clsr_pkg::PROD_W-1:0] prod_next;
    logic [clsr_pkg::HI_W-1:0]   hi_part;
    logic [clsr_pkg::FOLD_W-1:0] fold_const;
    logic [clsr_pkg::HI_W+clsr_pkg::FOLD_W-1:0] fold_val;
    logic [clsr_pkg::VAL_W:0]    sum;
    logic [clsr_pkg::VAL_W:0]    mod_ext;
    logic [clsr_pkg::VAL_W:0]    sum_sub;

    // multiply stage
    assign mul_const = ctl.sel_two ? clsr_pkg::MUL_TWO : clsr_pkg::MUL_ONE;
    assign prod_next = clsr_pkg::PROD_W'(operand) * clsr_pkg::PROD_W'(mul_const);

    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            prod_reg <= prod_next;
            sel_reg  <= ctl.sel_two;
        end
    end

    // fold high bits using 2^31 = fold (mod m), then one conditional subtract
    assign hi_part    = prod_reg[clsr_pkg::PROD_W-1:clsr_pkg::VAL_W];
    assign fold_const = sel_reg ? clsr_pkg::FOLD_TWO : clsr_pkg::FOLD_ONE;
    assign fold_val   = (clsr_pkg::HI_W+clsr_pkg::FOLD_W)'(hi_part)
                      * (clsr_pkg::HI_W+clsr_pkg::FOLD_W)'(fold_const);
    assign sum        = {1'b0, prod_reg[clsr_pkg::VAL_W-1:0]}
                      + (clsr_pkg::VAL_W+1)'(fold_val);
    assign mod_ext    = {1'b0, (sel_reg ? clsr_pkg::MOD_TWO : clsr_pkg::MOD_ONE)};
    assign sum_sub    = sum - mod_ext;
    assign result     = (sum >= mod_ext) ? sum_sub[clsr_pkg::VAL_W-1:0]
                                         : sum[clsr_pkg::VAL_W-1:0];

endmodule

### sv/clsr_slot_div.sv
// reciprocal-multiply divider that turns the last output into a table slot
`timescale 1ns / 1ps

module clsr_slot_div #(
    parameter int TABLE_SIZE = clsr_pkg::TABLE_SIZE_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [clsr_pkg::VAL_W-1:0] start_value,
    output logic                       done,
    output logic [$clog2(TABLE_SIZE+1)-1:0] quotient
);

    localparam int QW    = $clog2(TABLE_SIZE + 1);
    localparam logic [clsr_pkg::VAL_W-1:0] SLOT_DIV =
        clsr_pkg::VAL_W'(1 + clsr_pkg::TOP_VALUE / TABLE_SIZE);
    // floor(2^32 / divisor), never above the true reciprocal
    localparam longint RECIP_L = (longint'(1) << 32) / longint'(SLOT_DIV);
    localparam int     RW      = $clog2(RECIP_L + 1);
    localparam logic [RW-1:0] RECIP = RW'(RECIP_L);
    localparam int     PW      = clsr_pkg::VAL_W + RW;
    localparam int     BW      = clsr_pkg::VAL_W + QW;

    localparam logic [1:0] STAGE_EST = 2'd2;
    localparam logic [1:0] STAGE_FIX = 2'd1;

    logic [1:0]                 cnt_reg;
    logic [clsr_pkg::VAL_W-1:0] x_reg;
    logic [QW-1:0]              est_reg;
    logic [QW-1:0]              quo_reg;
    logic [PW-1:0]              prod;
    logic [BW-1:0]              back;
    logic [BW-1:0]              rem;
    logic                       fix;

    // estimate is the quotient or one below it
    assign prod = PW'(x_reg) * PW'(RECIP);

    // remainder check lifts the estimate by one where needed
    assign back = BW'(est_reg) * BW'(SLOT_DIV);
    assign rem  = BW'(x_reg) - back;
    assign fix  = (rem >= BW'(SLOT_DIV));

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= STAGE_EST;
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= start_value;
        end
        if (cnt_reg == STAGE_EST) begin
            est_reg <= QW'(prod[PW-1:32]);
        end
        if (cnt_reg == STAGE_FIX) begin
            quo_reg <= est_reg + QW'(fix);
        end
    end

    assign done     = (cnt_reg == '0);
    assign quotient = quo_reg;

endmodule

### sv/clsr_table.sv
// shuffle table memory with per-entry valid bits
`timescale 1ns / 1ps

module clsr_table #(
    parameter int TABLE_SIZE = clsr_pkg::TABLE_SIZE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr_en,
    input  logic [$clog2(TABLE_SIZE)-1:0] wr_addr,
    input  logic [clsr_pkg::VAL_W-1:0]    wr_data,
    input  logic                          rd_en,
    input  logic [$clog2(TABLE_SIZE)-1:0] rd_addr,
    output logic [clsr_pkg::VAL_W-1:0]    rd_data
);

    logic [clsr_pkg::VAL_W-1:0] mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0]      valid_reg;
    logic [clsr_pkg::VAL_W-1:0] rd_data_reg;
    logic                       rd_valid_reg;

    // valid bits, cleared by reset so unwritten slots read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

### sv/combined_lcg_shuffle_rng.sv
// top level: sequencer, generator state and output register
`timescale 1ns / 1ps

// Combined two-generator random source with a shuffle table. Each item
// returns one value in 1 .. 2147483562; divide by 2147483563 for a uniform
// value. For a draw, one shared 31x16 modular multiply unit steps the first
// and then the second generator (a multiply state and a reduce state each),
// while a reciprocal-multiply divider finds the table slot alongside; then
// one table read, a mix-and-refill step and the output register load follow.
// The block is ready again as the result is loaded into the output register.
// A reseed item first runs warm-up steps of the first generator through the
// same multiply unit, filling the table, and then draws. The block takes a
// new item only when the previous one has finished; a result waiting in the
// output register does not block acceptance, but the next item holds at its
// output step until that result is taken.
module combined_lcg_shuffle_rng #(
    parameter int TABLE_SIZE = clsr_pkg::TABLE_SIZE_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_kind,
    input  logic [clsr_pkg::VAL_W-1:0] s_seed,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [clsr_pkg::VAL_W-1:0] m_random_value
);

    localparam int IDX_W  = $clog2(TABLE_SIZE);
    localparam int QW     = $clog2(TABLE_SIZE + 1);
    localparam int STEP_W = $clog2(TABLE_SIZE + 8);
    localparam int VW     = clsr_pkg::VAL_W;

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b0000000001,
        ST_RS_MUL   = 10'b0000000010,
        ST_RS_RED   = 10'b0000000100,
        ST_G1_MUL   = 10'b0000001000,
        ST_G1_RED   = 10'b0000010000,
        ST_G2_MUL   = 10'b0000100000,
        ST_G2_RED   = 10'b0001000000,
        ST_WAIT_DIV = 10'b0010000000,
        ST_MIX      = 10'b0100000000,
        ST_OUT      = 10'b1000000000
    } state_t;

    state_t               state_reg, state_next;
    logic [VW-1:0]        gen1_reg, gen1_next;
    logic [VW-1:0]        gen2_reg, gen2_next;
    logic [VW-1:0]        last_reg, last_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [VW-1:0]        mix_reg, mix_next;
    logic                 m_valid_reg, m_valid_next;
    logic [VW-1:0]        m_value_reg, m_value_next;

    clsr_pkg::lehmer_ctl_t unit_ctl;
    logic [VW-1:0]        unit_operand;
    logic [VW-1:0]        unit_result;

    logic                 div_start;
    logic [VW-1:0]        div_value;
    logic                 div_done;
    logic [QW-1:0]        div_quo;
    logic [IDX_W-1:0]     slot;

    logic                 tbl_wr_en;
    logic [IDX_W-1:0]     tbl_wr_addr;
    logic [VW-1:0]        tbl_wr_data;
    logic                 tbl_rd_en;
    logic [VW-1:0]        tbl_rd_data;

    logic                 s_accept;
    logic [VW-1:0]        seed_eff;
    logic [VW+1:0]        diff;
    logic [VW+1:0]        mixed;

    // shared modular multiply unit
    clsr_lehmer_unit u_unit (
        .aclk    (aclk),
        .ctl     (unit_ctl),
        .operand (unit_operand),
        .result  (unit_result)
    );

    // slot index divider
    clsr_slot_div #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (div_start),
        .start_value (div_value),
        .done        (div_done),
        .quotient    (div_quo)
    );

    // shuffle table
    clsr_table #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (slot),
        .rd_data (tbl_rd_data)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign seed_eff = (s_seed == '0) ? VW'(1) : s_seed;

    // out-of-range quotient falls back to slot zero
    assign slot = (div_quo >= QW'(TABLE_SIZE)) ? '0 : div_quo[IDX_W-1:0];

    // output minus second generator, wrapped into 1 .. top
    assign diff  = {2'b00, tbl_rd_data} - {2'b00, gen2_reg};
    assign mixed = (diff[VW+1] || (diff == '0)) ? (diff + {2'b00, clsr_pkg::TOP_VALUE})
                                                 : diff;

    // sequencer and next-state logic
    always_comb begin
        state_next   = state_reg;
        gen1_next    = gen1_reg;
        gen2_next    = gen2_reg;
        last_next    = last_reg;
        step_next    = step_reg;
        mix_next     = mix_reg;
        m_valid_next = m_valid_reg;
        m_value_next = m_value_reg;

        unit_ctl.mul_en  = 1'b0;
        unit_ctl.sel_two = 1'b0;
        unit_operand     = gen1_reg;

        div_start   = 1'b0;
        div_value   = last_reg;
        tbl_wr_en   = 1'b0;
        tbl_wr_addr = step_reg[IDX_W-1:0];
        tbl_wr_data = unit_result;
        tbl_rd_en   = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_kind == clsr_pkg::KIND_RESEED) begin
                        gen1_next  = seed_eff;
                        gen2_next  = seed_eff;
                        step_next  = STEP_W'(TABLE_SIZE + 7);
                        state_next = ST_RS_MUL;
                    end else begin
                        div_start  = 1'b1;
                        state_next = ST_G1_MUL;
                    end
                end
            end
            ST_RS_MUL: begin
                unit_ctl.mul_en = 1'b1;
                state_next      = ST_RS_RED;
            end
            ST_RS_RED: begin
                gen1_next = unit_result;
                if (step_reg < STEP_W'(TABLE_SIZE)) begin
                    tbl_wr_en = 1'b1;
                end
                if (step_reg == '0) begin
                    last_next  = unit_result;
                    div_start  = 1'b1;
                    div_value  = unit_result;
                    state_next = ST_G1_MUL;
                end else begin
                    step_next  = step_reg - STEP_W'(1);
                    state_next = ST_RS_MUL;
                end
            end
            ST_G1_MUL: begin
                unit_ctl.mul_en = 1'b1;
                state_next      = ST_G1_RED;
            end
            ST_G1_RED: begin
                gen1_next  = unit_result;
                state_next = ST_G2_MUL;
            end
            ST_G2_MUL: begin
                unit_ctl.mul_en  = 1'b1;
                unit_ctl.sel_two = 1'b1;
                unit_operand     = gen2_reg;
                state_next       = ST_G2_RED;
            end
            ST_G2_RED: begin
                gen2_next  = unit_result;
                state_next = ST_WAIT_DIV;
            end
            ST_WAIT_DIV: begin
                if (div_done) begin
                    tbl_rd_en  = 1'b1;
                    state_next = ST_MIX;
                end
            end
            ST_MIX: begin
                // refill the slot just read with the new first generator
                tbl_wr_en   = 1'b1;
                tbl_wr_addr = slot;
                tbl_wr_data = gen1_reg;
                mix_next    = mixed[VW-1:0];
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_value_next = mix_reg;
                    last_next    = mix_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and generator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            gen1_reg    <= clsr_pkg::FIRST_RESET;
            gen2_reg    <= clsr_pkg::SECOND_RESET;
            last_reg    <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            gen1_reg    <= gen1_next;
            gen2_reg    <= gen2_next;
            last_reg    <= last_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        mix_reg     <= mix_next;
        m_value_reg <= m_value_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_random_value = m_value_reg;

endmodule

### tb/tb_top.sv
// self-checking testbench for the combined lcg shuffle random generator
`timescale 1ns / 1ps

module tb_top;
    import clsr_pkg::*;

    localparam int    TABLE_DEPTH = TABLE_SIZE_DEF;
    // width of the value range that maps onto one table slot
    localparam longint SLOT_SPAN  = 1 + longint'(TOP_VALUE) / TABLE_DEPTH;
    localparam int    PHASE_ITEMS = 100;
    localparam int    NUM_PHASES  = 4;
    localparam int    SEND_IDLE  [NUM_PHASES] = '{0, 57, 0, 30};
    localparam int    RECV_STALL [NUM_PHASES] = '{0, 0, 57, 30};

    // one directed row: the item and, where known up front, its value
    typedef struct packed {
        logic             kind;
        logic [VAL_W-1:0] seed;
        logic             known;
        logic [VAL_W-1:0] value;
    } stim_row_t;

    localparam int NUM_ROWS = 22;
    localparam stim_row_t DIR_ROWS [NUM_ROWS] = '{
        // first draw out of reset: slot 0 is zero, so the value wraps
        '{KIND_DRAW,   31'd0,            1'b1, 31'd1407495835},
        '{KIND_DRAW,   31'h7FFF_FFFF,    1'b0, 31'd0},
        '{KIND_DRAW,   31'd0,            1'b0, 31'd0},
        // zero seed reads as one
        '{KIND_RESEED, 31'd0,            1'b0, 31'd0},
        '{KIND_DRAW,   31'd12345,        1'b0, 31'd0},
        '{KIND_RESEED, 31'd1,            1'b0, 31'd0},
        // seed above both moduli
        '{KIND_RESEED, 31'h7FFF_FFFF,    1'b0, 31'd0},
        '{KIND_DRAW,   31'd0,            1'b0, 31'd0},
        // first generator stuck at zero
        '{KIND_RESEED, MOD_ONE,          1'b0, 31'd0},
        '{KIND_DRAW,   31'd0,            1'b0, 31'd0},
        '{KIND_DRAW,   31'h7FFF_FFFF,    1'b0, 31'd0},
        // second generator stuck at zero
        '{KIND_RESEED, MOD_TWO,          1'b0, 31'd0},
        '{KIND_DRAW,   31'd0,            1'b0, 31'd0},
        '{KIND_DRAW,   31'd0,            1'b0, 31'd0},
        '{KIND_RESEED, TOP_VALUE,        1'b0, 31'd0},
        '{KIND_RESEED, MOD_TWO - 31'd1,  1'b0, 31'd0},
        '{KIND_RESEED, 31'h4000_0000,    1'b0, 31'd0},
        '{KIND_RESEED, 31'h2AAA_AAAA,    1'b0, 31'd0},
        '{KIND_RESEED, 31'h5555_5555,    1'b0, 31'd0},
        '{KIND_DRAW,   31'd0,            1'b0, 31'd0},
        '{KIND_DRAW,   31'h2AAA_AAAA,    1'b0, 31'd0},
        '{KIND_DRAW,   31'd0,            1'b0, 31'd0}
    };

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic             s_kind;
    logic [VAL_W-1:0] s_seed;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [VAL_W-1:0] m_random_value;

    // predictor copy of the generator state
    logic [VAL_W-1:0] gen_one;
    logic [VAL_W-1:0] gen_two;
    logic [VAL_W-1:0] prev_value;
    logic [VAL_W-1:0] shuffle_slots [TABLE_DEPTH];

    logic [VAL_W-1:0] pending_values [$];
    int               err_count = 0;
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;

    combined_lcg_shuffle_rng u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_seed         (s_seed),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_random_value (m_random_value)
    );

    // clock
    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // exact modular multiply in 64 bits
    function automatic logic [VAL_W-1:0] mod_mul(input logic [VAL_W-1:0] x,
                                                 input longint mul,
                                                 input longint modulus);
        longint xv;
        xv = longint'(x);
        return VAL_W'((xv * mul) % modulus);
    endfunction

    // advance the predictor by one item and return its value
    function automatic logic [VAL_W-1:0] predict_value(input logic kind,
                                                       input logic [VAL_W-1:0] seed);
        logic [VAL_W-1:0] start;
        int               slot;
        longint           mixed;
        if (kind == KIND_RESEED) begin
            start   = (seed == '0) ? VAL_W'(1) : seed;
            gen_one = start;
            gen_two = start;
            // warm-up, last steps fill the table from the top slot down
            for (int step = TABLE_DEPTH + 7; step >= 0; step--) begin
                gen_one = mod_mul(gen_one, longint'(MUL_ONE), longint'(MOD_ONE));
                if (step < TABLE_DEPTH) begin
                    shuffle_slots[step] = gen_one;
                end
            end
            prev_value = shuffle_slots[0];
        end
        gen_one = mod_mul(gen_one, longint'(MUL_ONE), longint'(MOD_ONE));
        gen_two = mod_mul(gen_two, longint'(MUL_TWO), longint'(MOD_TWO));
        slot = int'(longint'(prev_value) / SLOT_SPAN);
        if (slot >= TABLE_DEPTH) begin
            slot = 0;
        end
        mixed = longint'(shuffle_slots[slot]) - longint'(gen_two);
        shuffle_slots[slot] = gen_one;
        if (mixed < 1) begin
            mixed += longint'(TOP_VALUE);
        end
        prev_value = VAL_W'(mixed);
        return prev_value;
    endfunction

    // offer one item, wait for acceptance, then queue its value
    task automatic send_item(input logic kind, input logic [VAL_W-1:0] seed,
                             input logic known, input logic [VAL_W-1:0] known_value);
        logic [VAL_W-1:0] predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_seed  <= seed;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predicted = predict_value(kind, seed);
        pending_values.push_back(known ? known_value : predicted);
    endtask

    // hold off the sender until every queued value has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_values.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // receiver backpressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // compare each returned item with the oldest queued value
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin : check_blk
            logic [VAL_W-1:0] want_value;
            if (pending_values.size() == 0) begin
                err_count++;
                $display("%0t: unexpected random_value %0d, expected none",
                         $time, m_random_value);
            end else begin
                want_value = pending_values.pop_front();
                if (m_random_value !== want_value) begin
                    err_count++;
                    $display("%0t: random_value mismatch, expected %0d, got %0d",
                             $time, want_value, m_random_value);
                end
            end
        end
    end

    // stimulus: directed rows, then random phases with different idling
    initial begin
        logic             kind;
        logic [VAL_W-1:0] seed;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_kind  = KIND_DRAW;
        s_seed  = '0;
        gen_one    = FIRST_RESET;
        gen_two    = SECOND_RESET;
        prev_value = '0;
        foreach (shuffle_slots[i]) begin
            shuffle_slots[i] = '0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIR_ROWS[i]) begin
            send_item(DIR_ROWS[i].kind, DIR_ROWS[i].seed, DIR_ROWS[i].known,
                      DIR_ROWS[i].value);
        end
        wait_drained();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            send_idle_pct  = SEND_IDLE[phase];
            recv_stall_pct = RECV_STALL[phase];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                kind = ($urandom_range(99) < 8) ? KIND_RESEED : KIND_DRAW;
                case ($urandom_range(15))
                    0:       seed = '0;
                    1:       seed = MOD_ONE;
                    2:       seed = MOD_TWO;
                    3:       seed = '1;
                    default: seed = VAL_W'($urandom);
                endcase
                send_item(kind, seed, 1'b0, '0);
            end
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        if (err_count == 0) begin
            $display("combined_lcg_shuffle_rng test passed");
        end else begin
            $display("combined_lcg_shuffle_rng test failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("combined_lcg_shuffle_rng test failed");
        $finish;
    end

endmodule
